// ----- rtl/dcs_pkg.sv -----
// Shared constants, codes and saturation helpers for the disk collision block.
// Used by the divider, the stepper and the checker; no dependencies.
package dcs_pkg;

  localparam int MaxBallsDef = 16;

  // Register reset values
  localparam logic [10:0] ArenaWidthRst  = 11'd800;
  localparam logic [10:0] ArenaHeightRst = 11'd600;
  localparam logic [7:0]  BallRadiusRst  = 8'd40;

  // Register indexes
  localparam logic [1:0] CFG_ARENA_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_ARENA_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BALL_RADIUS  = 2'd2;

  // Operations and result kinds
  localparam logic       OP_ADD  = 1'b0;
  localparam logic       OP_TICK = 1'b1;
  localparam logic [1:0] KIND_ADD_OK  = 2'd0;
  localparam logic [1:0] KIND_ADD_REJ = 2'd1;
  localparam logic [1:0] KIND_REPORT  = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  // Shared multiplier, divider and RAM entry widths
  localparam int MulAW  = 36;
  localparam int MulBW  = 18;
  localparam int ProdW  = 54;
  localparam int DsqW   = 34;
  localparam int QuoW   = 18;
  localparam int EntryW = 64;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == 16'sh8000) begin
      r = 16'sh7fff;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

// ----- rtl/dcs_if.sv -----
// Valid/ready channel interfaces for the input items and result items.
// Depends on nothing; the payload follows the field list of the block.
interface dcs_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [10:0]        click_x;
  logic [10:0]        click_y;
  logic signed [15:0] new_vel_x;
  logic signed [15:0] new_vel_y;
  logic [15:0]        step_time;

  modport source (output valid, operation, click_x, click_y, new_vel_x, new_vel_y,
                  step_time, input ready);
  modport sink   (input valid, operation, click_x, click_y, new_vel_x, new_vel_y,
                  step_time, output ready);
endinterface

interface dcs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [5:0]         disk_index;
  logic signed [15:0] disk_x;
  logic signed [15:0] disk_y;
  logic signed [15:0] disk_vel_x;
  logic signed [15:0] disk_vel_y;
  logic               last;

  modport source (output valid, kind, disk_index, disk_x, disk_y, disk_vel_x, disk_vel_y,
                  last, input ready);
  modport sink   (input valid, kind, disk_index, disk_x, disk_y, disk_vel_x, disk_vel_y,
                  last, output ready);
endinterface

// ----- rtl/dcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcs_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dcs_div.sv -----
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Uses dcs_pkg widths; the quotient magnitude is known to fit in QuoW bits.
module dcs_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [dcs_pkg::ProdW-1:0] num_i,
  input  logic [dcs_pkg::DsqW-1:0]         den_i,
  output logic                             done_o,
  output logic signed [dcs_pkg::QuoW:0]    quo_o
);
  import dcs_pkg::*;

  localparam int CntW = $clog2(QuoW);

  logic              busy_q, done_q, neg_q;
  logic [CntW-1:0]   cnt_q;
  logic [DsqW-1:0]   rem_q, den_q;
  logic [QuoW-1:0]   sh_q;
  logic [ProdW-1:0]  mag;
  logic [DsqW:0]     trial;
  logic              ge;

  assign mag   = num_i[ProdW-1] ? ProdW'(-num_i) : ProdW'(num_i);
  assign trial = {rem_q, sh_q[QuoW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QuoW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Upper numerator bits already lie below the divisor, so start there
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= mag[DsqW+QuoW-1:QuoW];
      sh_q  <= mag[QuoW-1:0];
      den_q <= den_i;
      neg_q <= num_i[ProdW-1];
    end else if (busy_q) begin
      rem_q <= ge ? DsqW'(trial - {1'b0, den_q}) : trial[DsqW-1:0];
      sh_q  <= {sh_q[QuoW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, sh_q}) : $signed({1'b0, sh_q});

endmodule

// ----- rtl/disk_collision_sim_step.sv -----
// Disk collision stepper: an add transaction checks the new disk against every stored
// disk; a tick moves each disk, checks it against every later disk, exchanges velocity
// for each touching pair with distinct centres (two 18-step divisions on the shared
// divider), bounces it off the walls and then reports every disk. All products go
// through one shared 36x18 multiplier and all disk state lives in one single-port-read
// RAM.
// No input is taken until every result of the current transaction has been loaded.
module disk_collision_sim_step #(
  parameter int MaxBalls = dcs_pkg::MaxBallsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  dcs_in_if.sink      in_i,
  dcs_out_if.source   out_o
);
  import dcs_pkg::*;

  localparam int IdxW = $clog2(MaxBalls);
  localparam int CntW = $clog2(MaxBalls + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LIM    = 5'd1;
  localparam logic [4:0] S_LIMW   = 5'd2;
  localparam logic [4:0] S_A_RD   = 5'd3;
  localparam logic [4:0] S_A_LAT  = 5'd4;
  localparam logic [4:0] S_SQX    = 5'd5;
  localparam logic [4:0] S_SQY    = 5'd6;
  localparam logic [4:0] S_SQS    = 5'd7;
  localparam logic [4:0] S_CMP    = 5'd8;
  localparam logic [4:0] S_A_RES  = 5'd9;
  localparam logic [4:0] S_EMPTY  = 5'd10;
  localparam logic [4:0] S_TI_RD  = 5'd11;
  localparam logic [4:0] S_TI_LAT = 5'd12;
  localparam logic [4:0] S_MX     = 5'd13;
  localparam logic [4:0] S_MY     = 5'd14;
  localparam logic [4:0] S_MW     = 5'd15;
  localparam logic [4:0] S_J_RD   = 5'd16;
  localparam logic [4:0] S_J_LAT  = 5'd17;
  localparam logic [4:0] S_DTX    = 5'd18;
  localparam logic [4:0] S_DTY    = 5'd19;
  localparam logic [4:0] S_DTS    = 5'd20;
  localparam logic [4:0] S_KXM    = 5'd21;
  localparam logic [4:0] S_KXD    = 5'd22;
  localparam logic [4:0] S_KXW    = 5'd23;
  localparam logic [4:0] S_KYM    = 5'd24;
  localparam logic [4:0] S_KYD    = 5'd25;
  localparam logic [4:0] S_KYW    = 5'd26;
  localparam logic [4:0] S_UPD    = 5'd27;
  localparam logic [4:0] S_WALL   = 5'd28;
  localparam logic [4:0] S_E_RD   = 5'd29;
  localparam logic [4:0] S_E_LAT  = 5'd30;

  // Control
  logic [4:0]      state_q;
  logic            op_q, blocked_q, ovalid_q;
  logic [CntW-1:0] cnt_q, i_q, j_q, i_nx, j_nx;
  logic [10:0]     aw_q, ah_q;
  logic [7:0]      rad_q;

  // Datapath
  logic [15:0]        dt_q;
  logic [25:0]        lim_q;
  logic signed [15:0] px_q, py_q, vxi_q, vyi_q, xi_q, yi_q;
  logic signed [15:0] xj_q, yj_q, vxj_q, vyj_q;
  logic signed [16:0] dx_q, dy_q, dvx_q, dvy_q;
  logic signed [ProdW-1:0] prod_q;
  logic [DsqW-1:0]    acc_q, dsq_q;
  logic signed [33:0] dacc_q;
  logic signed [34:0] dot_q;
  logic signed [QuoW:0] kx_q, ky_q;

  // Output register
  logic [1:0]         okind_q;
  logic [5:0]         oidx_q;
  logic signed [15:0] ox_q, oy_q, ovx_q, ovy_q;
  logic               olast_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;

  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr, ram_raddr;
  logic [EntryW-1:0]  ram_wdata, ram_rdata;
  logic signed [15:0] rd_x, rd_y, rd_vx, rd_vy;

  logic               div_start, div_done;
  logic signed [QuoW:0] div_quo;

  logic               out_free, out_load, touch;
  logic [1:0]         okind_d;
  logic [5:0]         oidx_d;
  logic signed [15:0] ox_d, oy_d, ovx_d, ovy_d;
  logic               olast_d;

  logic signed [15:0] mv_base, mv_pos;
  logic signed [33:0] mv_t;
  logic signed [15:0] vxi_upd, vyi_upd, vxj_upd, vyj_upd;
  logic signed [18:0] r16s, px19, py19, wx19, hy19;
  logic signed [15:0] wvx1, wvx2, wvy1, wvy2;

  assign rd_x  = ram_rdata[63:48];
  assign rd_y  = ram_rdata[47:32];
  assign rd_vx = ram_rdata[31:16];
  assign rd_vy = ram_rdata[15:0];

  assign i_nx     = i_q + 1'b1;
  assign j_nx     = j_q + 1'b1;
  assign out_free = !ovalid_q || out_o.ready;
  assign touch    = dsq_q <= DsqW'(lim_q);

  dcs_ram #(.Width(EntryW), .Depth(MaxBalls)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign div_start = (state_q == S_KXD) || (state_q == S_KYD);

  dcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (dsq_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_LIM: begin
        mul_a = MulAW'({rad_q, 5'b0});
        mul_b = MulBW'({rad_q, 5'b0});
      end
      S_MX: begin
        mul_a = MulAW'(vxi_q);
        mul_b = MulBW'({1'b0, dt_q});
      end
      S_MY: begin
        mul_a = MulAW'(vyi_q);
        mul_b = MulBW'({1'b0, dt_q});
      end
      S_SQX: begin
        mul_a = MulAW'(dx_q);
        mul_b = MulBW'(dx_q);
      end
      S_SQY: begin
        mul_a = MulAW'(dy_q);
        mul_b = MulBW'(dy_q);
      end
      S_DTX: begin
        mul_a = MulAW'(dvx_q);
        mul_b = MulBW'(dx_q);
      end
      S_DTY: begin
        mul_a = MulAW'(dvy_q);
        mul_b = MulBW'(dy_q);
      end
      S_KXM: begin
        mul_a = MulAW'(dot_q);
        mul_b = MulBW'(dx_q);
      end
      S_KYM: begin
        mul_a = MulAW'(dot_q);
        mul_b = MulBW'(dy_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Move: round product to nearest, ties up, then saturate the new position
  assign mv_base = (state_q == S_MY) ? xi_q : yi_q;
  assign mv_t    = $signed(prod_q[33:0]) + 34'sd32768;
  assign mv_pos  = sat16(20'(mv_base) + 20'($signed(mv_t[33:16])));

  assign vxi_upd = sat16(20'(vxi_q) - 20'(kx_q));
  assign vyi_upd = sat16(20'(vyi_q) - 20'(ky_q));
  assign vxj_upd = sat16(20'(vxj_q) + 20'(kx_q));
  assign vyj_upd = sat16(20'(vyj_q) + 20'(ky_q));

  // Walls: right/bottom first, then left/top on the possibly flipped velocity
  assign r16s = $signed({7'b0, rad_q, 4'b0});
  assign px19 = 19'(px_q);
  assign py19 = 19'(py_q);
  assign wx19 = $signed({4'b0, aw_q, 4'b0});
  assign hy19 = $signed({4'b0, ah_q, 4'b0});
  assign wvx1 = ((px19 + r16s >= wx19) && (vxi_q > 16'sd0)) ? neg_sat16(vxi_q) : vxi_q;
  assign wvx2 = ((px19 < r16s) && (wvx1 < 16'sd0)) ? neg_sat16(wvx1) : wvx1;
  assign wvy1 = ((py19 + r16s >= hy19) && (vyi_q > 16'sd0)) ? neg_sat16(vyi_q) : vyi_q;
  assign wvy2 = ((py19 < r16s) && (wvy1 < 16'sd0)) ? neg_sat16(wvy1) : wvy1;

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_q[IdxW-1:0];
    ram_wdata = {px_q, py_q, vxi_q, vyi_q};
    ram_raddr = i_q[IdxW-1:0];
    case (state_q)
      S_A_RES: begin
        ram_we    = out_free && !blocked_q;
        ram_waddr = cnt_q[IdxW-1:0];
      end
      S_J_RD: begin
        ram_raddr = j_q[IdxW-1:0];
      end
      S_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IdxW-1:0];
        ram_wdata = {xj_q, yj_q, vxj_upd, vyj_upd};
      end
      S_WALL: begin
        ram_we    = 1'b1;
        ram_wdata = {px_q, py_q, wvx2, wvy2};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Result selection
  always_comb begin
    out_load = 1'b0;
    okind_d  = KIND_REPORT;
    oidx_d   = 6'(i_q);
    ox_d     = rd_x;
    oy_d     = rd_y;
    ovx_d    = rd_vx;
    ovy_d    = rd_vy;
    olast_d  = 1'b1;
    case (state_q)
      S_A_RES: begin
        out_load = out_free;
        if (blocked_q) begin
          okind_d = KIND_ADD_REJ;
          oidx_d  = '0;
          ox_d    = '0;
          oy_d    = '0;
          ovx_d   = '0;
          ovy_d   = '0;
        end else begin
          okind_d = KIND_ADD_OK;
          oidx_d  = 6'(cnt_q);
          ox_d    = px_q;
          oy_d    = py_q;
          ovx_d   = vxi_q;
          ovy_d   = vyi_q;
        end
      end
      S_EMPTY: begin
        out_load = out_free;
        okind_d  = KIND_EMPTY;
        oidx_d   = '0;
        ox_d     = '0;
        oy_d     = '0;
        ovx_d    = '0;
        ovy_d    = '0;
      end
      S_E_LAT: begin
        out_load = out_free;
        olast_d  = (i_nx == cnt_q);
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_ADD;
      blocked_q <= 1'b0;
      ovalid_q  <= 1'b0;
      cnt_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      aw_q      <= ArenaWidthRst;
      ah_q      <= ArenaHeightRst;
      rad_q     <= BallRadiusRst;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ARENA_WIDTH:  aw_q  <= cfg_wdata_i;
          CFG_ARENA_HEIGHT: ah_q  <= cfg_wdata_i;
          CFG_BALL_RADIUS:  rad_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end

      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q    <= in_i.operation;
            state_q <= S_LIM;
          end
        end
        S_LIM: state_q <= S_LIMW;
        S_LIMW: begin
          i_q <= '0;
          if (op_q == OP_ADD) begin
            blocked_q <= (cnt_q == CntW'(MaxBalls));
            state_q   <= S_A_RD;
          end else if (cnt_q == '0) begin
            state_q <= S_EMPTY;
          end else begin
            state_q <= S_TI_RD;
          end
        end
        S_A_RD:  state_q <= (i_q == cnt_q) ? S_A_RES : S_A_LAT;
        S_A_LAT: state_q <= S_SQX;
        S_SQX:   state_q <= S_SQY;
        S_SQY:   state_q <= S_SQS;
        S_SQS:   state_q <= S_CMP;
        S_CMP: begin
          if (op_q == OP_ADD) begin
            if (touch) begin
              blocked_q <= 1'b1;
            end
            i_q     <= i_nx;
            state_q <= S_A_RD;
          end else if (touch && (dsq_q != '0)) begin
            state_q <= S_DTX;
          end else begin
            j_q     <= j_nx;
            state_q <= (j_nx < cnt_q) ? S_J_RD : S_WALL;
          end
        end
        S_A_RES: begin
          if (out_free) begin
            if (!blocked_q) begin
              cnt_q <= cnt_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_TI_RD:  state_q <= S_TI_LAT;
        S_TI_LAT: state_q <= S_MX;
        S_MX:     state_q <= S_MY;
        S_MY:     state_q <= S_MW;
        S_MW: begin
          j_q     <= i_nx;
          state_q <= (i_nx < cnt_q) ? S_J_RD : S_WALL;
        end
        S_J_RD:  state_q <= S_J_LAT;
        S_J_LAT: state_q <= S_SQX;
        S_DTX:   state_q <= S_DTY;
        S_DTY:   state_q <= S_DTS;
        S_DTS:   state_q <= S_KXM;
        S_KXM:   state_q <= S_KXD;
        S_KXD:   state_q <= S_KXW;
        S_KXW: begin
          if (div_done) begin
            state_q <= S_KYM;
          end
        end
        S_KYM: state_q <= S_KYD;
        S_KYD: state_q <= S_KYW;
        S_KYW: begin
          if (div_done) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          j_q     <= j_nx;
          state_q <= (j_nx < cnt_q) ? S_J_RD : S_WALL;
        end
        S_WALL: begin
          if (i_nx < cnt_q) begin
            i_q     <= i_nx;
            state_q <= S_TI_RD;
          end else begin
            i_q     <= '0;
            state_q <= S_E_RD;
          end
        end
        S_E_RD: state_q <= S_E_LAT;
        S_E_LAT: begin
          if (out_free) begin
            i_q     <= i_nx;
            state_q <= (i_nx == cnt_q) ? S_IDLE : S_E_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        dt_q  <= in_i.step_time;
        px_q  <= $signed({1'b0, in_i.click_x, 4'b0});
        py_q  <= $signed({1'b0, in_i.click_y, 4'b0});
        vxi_q <= in_i.new_vel_x;
        vyi_q <= in_i.new_vel_y;
      end
      S_LIMW: lim_q <= prod_q[25:0];
      S_A_LAT, S_J_LAT: begin
        dx_q  <= 17'(px_q) - 17'(rd_x);
        dy_q  <= 17'(py_q) - 17'(rd_y);
        dvx_q <= 17'(vxi_q) - 17'(rd_vx);
        dvy_q <= 17'(vyi_q) - 17'(rd_vy);
        xj_q  <= rd_x;
        yj_q  <= rd_y;
        vxj_q <= rd_vx;
        vyj_q <= rd_vy;
      end
      S_SQY: acc_q <= prod_q[DsqW-1:0];
      S_SQS: dsq_q <= acc_q + prod_q[DsqW-1:0];
      S_TI_LAT: begin
        xi_q  <= rd_x;
        yi_q  <= rd_y;
        vxi_q <= rd_vx;
        vyi_q <= rd_vy;
      end
      S_MY: px_q <= mv_pos;
      S_MW: py_q <= mv_pos;
      S_DTY: dacc_q <= $signed(prod_q[33:0]);
      S_DTS: dot_q  <= 35'(dacc_q) + 35'($signed(prod_q[33:0]));
      S_KXW: begin
        if (div_done) begin
          kx_q <= div_quo;
        end
      end
      S_KYW: begin
        if (div_done) begin
          ky_q <= div_quo;
        end
      end
      S_UPD: begin
        vxi_q <= vxi_upd;
        vyi_q <= vyi_upd;
      end
      default: ;
    endcase

    if (out_load) begin
      okind_q <= okind_d;
      oidx_q  <= oidx_d;
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      ovx_q   <= ovx_d;
      ovy_q   <= ovy_d;
      olast_q <= olast_d;
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = ovalid_q;
  assign out_o.kind       = okind_q;
  assign out_o.disk_index = oidx_q;
  assign out_o.disk_x     = ox_q;
  assign out_o.disk_y     = oy_q;
  assign out_o.disk_vel_x = ovx_q;
  assign out_o.disk_vel_y = ovy_q;
  assign out_o.last       = olast_q;

endmodule

// ----- rtl/dcs_checker.sv -----
// Port-level checks for disk_collision_sim_step, attached by bind.
// Depends on dcs_pkg for the result kind codes.
module dcs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         out_kind_i,
  input logic [5:0]         out_disk_index_i,
  input logic signed [15:0] out_disk_x_i,
  input logic               out_last_i
);
  import dcs_pkg::*;

  // Add and empty-tick results stand alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KIND_REPORT) |-> out_last_i)
    else $error("single result without last");

  // No new transaction while a report sequence is still coming
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input taken during report sequence");

  // Rejected add carries zero index and zero x position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_ADD_REJ) |->
      (out_disk_index_i == '0) && (out_disk_x_i == '0))
    else $error("rejected add with payload");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
      $stable(out_disk_x_i))
    else $error("stalled result changed");

endmodule

bind disk_collision_sim_step dcs_checker u_dcs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_disk_index_i (out_o.disk_index),
  .out_disk_x_i     (out_o.disk_x),
  .out_last_i       (out_o.last)
);

// ----- tb/sv/tb_disk_collision_sim_step_chk.sv -----
// Checker for the disk collision stepper: watches both channels and the register port,
// predicts every result from its own copy of the disk store, and counts mismatches.
// Depends on dcs_pkg and the channel interfaces in dcs_if.sv.
module tb_disk_collision_sim_step_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  dcs_in_if.sink      in_mon,
  dcs_out_if.sink     out_mon,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dcs_pkg::*;

  localparam int NBalls = MaxBallsDef;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         idx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               last;
  } disk_rec_t;

  disk_rec_t   want_q[$];
  logic [10:0] width_r, height_r;
  logic [7:0]  radius_r;
  longint      px_s[NBalls], py_s[NBalls], vx_s[NBalls], vy_s[NBalls];
  int          n_disks;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = want_q.size();

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint floor_q16(longint v);
    if (v >= 0) return v >>> 16;
    return -((-v + 65535) >>> 16);
  endfunction

  function automatic longint quot_trunc(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n) / d);
  endfunction

  function automatic disk_rec_t mk(logic [1:0] k, int i, longint x, longint y,
                                   longint vx, longint vy, logic l);
    disk_rec_t r;
    r.kind = k; r.idx = i[5:0]; r.x = x[15:0]; r.y = y[15:0];
    r.vx = vx[15:0]; r.vy = vy[15:0]; r.last = l;
    return r;
  endfunction

  // Append one predicted result at the tail of the queue
  function automatic void queue_want(disk_rec_t r);
    want_q.insert(want_q.size(), r);
  endfunction

  task automatic place_disk(logic [10:0] cx, logic [10:0] cy,
                            logic signed [15:0] nvx, logic signed [15:0] nvy);
    longint x, y, lim, dx, dy;
    bit     blocked;
    x = longint'(cx) * 16;
    y = longint'(cy) * 16;
    lim = (longint'(radius_r) * 32) ** 2;
    blocked = (n_disks >= NBalls);
    for (int i = 0; i < n_disks; i++) begin
      dx = x - px_s[i];
      dy = y - py_s[i];
      if (dx * dx + dy * dy <= lim) blocked = 1;
    end
    if (blocked) begin
      queue_want(mk(KIND_ADD_REJ, 0, 0, 0, 0, 0, 1'b1));
    end else begin
      px_s[n_disks] = x; py_s[n_disks] = y;
      vx_s[n_disks] = nvx; vy_s[n_disks] = nvy;
      queue_want(mk(KIND_ADD_OK, n_disks, x, y, nvx, nvy, 1'b1));
      n_disks++;
    end
  endtask

  task automatic advance_disks(logic [15:0] dt_in);
    longint dt, lim, r16, nx, ny, dx, dy, dsq, dot, kx, ky;
    dt = dt_in;
    lim = (longint'(radius_r) * 32) ** 2;
    r16 = longint'(radius_r) * 16;
    if (n_disks == 0) begin
      queue_want(mk(KIND_EMPTY, 0, 0, 0, 0, 0, 1'b1));
      return;
    end
    for (int i = 0; i < n_disks; i++) begin
      nx = clamp16(px_s[i] + floor_q16(vx_s[i] * dt + 32768));
      ny = clamp16(py_s[i] + floor_q16(vy_s[i] * dt + 32768));
      for (int j = i + 1; j < n_disks; j++) begin
        dx = nx - px_s[j];
        dy = ny - py_s[j];
        dsq = dx * dx + dy * dy;
        // coincident centres have no contact normal: skip the pair
        if (dsq != 0 && dsq <= lim) begin
          dot = (vx_s[i] - vx_s[j]) * dx + (vy_s[i] - vy_s[j]) * dy;
          kx = quot_trunc(dot * dx, dsq);
          ky = quot_trunc(dot * dy, dsq);
          vx_s[i] = clamp16(vx_s[i] - kx); vy_s[i] = clamp16(vy_s[i] - ky);
          vx_s[j] = clamp16(vx_s[j] + kx); vy_s[j] = clamp16(vy_s[j] + ky);
        end
      end
      if (nx + r16 >= longint'(width_r) * 16 && vx_s[i] > 0) vx_s[i] = clamp16(-vx_s[i]);
      if (nx < r16 && vx_s[i] < 0) vx_s[i] = clamp16(-vx_s[i]);
      if (ny + r16 >= longint'(height_r) * 16 && vy_s[i] > 0) vy_s[i] = clamp16(-vy_s[i]);
      if (ny < r16 && vy_s[i] < 0) vy_s[i] = clamp16(-vy_s[i]);
      px_s[i] = nx; py_s[i] = ny;
    end
    for (int i = 0; i < n_disks; i++)
      queue_want(mk(KIND_REPORT, i, px_s[i], py_s[i], vx_s[i], vy_s[i],
                    i == n_disks - 1));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    disk_rec_t got, exp_r;
    if (!rst_ni) begin
      width_r = ArenaWidthRst; height_r = ArenaHeightRst; radius_r = BallRadiusRst;
      n_disks = 0; fails = 0;
      want_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ARENA_WIDTH:  width_r = cfg_wdata_i;
          CFG_ARENA_HEIGHT: height_r = cfg_wdata_i;
          CFG_BALL_RADIUS:  radius_r = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = mk(out_mon.kind, out_mon.disk_index, out_mon.disk_x, out_mon.disk_y,
                 out_mon.disk_vel_x, out_mon.disk_vel_y, out_mon.last);
        if (want_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = want_q.pop_front();
          if (got !== exp_r) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p got %p", exp_r, got);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_ADD)
          place_disk(in_mon.click_x, in_mon.click_y, in_mon.new_vel_x, in_mon.new_vel_y);
        else
          advance_disks(in_mon.step_time);
      end
    end
  end
endmodule

// ----- tb/sv/tb_disk_collision_sim_step.sv -----
// Top of the disk collision stepper testbench: clock, reset, register writes, stimulus
// with random gaps and stalls, and the verdict. Depends on dcs_pkg, dcs_if.sv, the block
// and the checker tb_disk_collision_sim_step_chk.
module tb_disk_collision_sim_step;
  timeunit 1ns;
  timeprecision 1ps;
  import dcs_pkg::*;

  localparam int IdleLimit = 60000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_ARENA_WIDTH;
  logic [10:0] cfg_wdata_i = '0;
  int          fail_count, pending;
  int          idle_cycles;
  bit          hold_off = 0;
  bit          stall_rand = 1;

  dcs_in_if  in_ch ();
  dcs_out_if out_ch ();

  disk_collision_sim_step dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  tb_disk_collision_sim_step_chk chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 0; in_ch.operation = OP_ADD; in_ch.click_x = 0; in_ch.click_y = 0;
    in_ch.new_vel_x = 0; in_ch.new_vel_y = 0; in_ch.step_time = 0;
    out_ch.ready = 0;
  end

  // Receiver: random stall per result, or a long hold-off when asked.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(negedge clk_i);
        hold_off = 0;
      end
      gap = stall_rand ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_disk_collision_sim_step: errors");
      $finish;
    end
  end

  // Valid stays up after a transaction until the next gap or a drain drops it
  task automatic send(logic op, logic [10:0] cx, logic [10:0] cy,
                      logic [15:0] vx, logic [15:0] vy, logic [15:0] dt, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1; in_ch.operation <= op;
    in_ch.click_x <= cx; in_ch.click_y <= cy;
    in_ch.new_vel_x <= vx; in_ch.new_vel_y <= vy; in_ch.step_time <= dt;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // an add has finished scanning the store before its result is loaded
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic add_disk(logic [10:0] cx, logic [10:0] cy, logic [15:0] vx,
                          logic [15:0] vy, bit gaps);
    send(OP_ADD, cx, cy, vx, vy, 16'($urandom), gaps);
  endtask

  task automatic tick(logic [15:0] dt, bit gaps);
    send(OP_TICK, 11'($urandom), 11'($urandom), 16'($urandom), 16'($urandom), dt, gaps);
  endtask

  task automatic random_phase(int n_items);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 2) == 0)
        tick($urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000)), 1);
      else
        add_disk(11'($urandom_range(0, 900)), 11'($urandom_range(0, 700)),
                 $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8000) - 4000),
                 $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8000) - 4000),
                 1);
    end
  endtask

  initial begin
    idle_cycles = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty tick, adds at extremes, add on top, head-on pair.
    tick(16'd1000, 0);
    add_disk(11'd0, 11'd0, 16'h8000, 16'h8000, 0);
    add_disk(11'd2047, 11'd2047, 16'h7fff, 16'h7fff, 0);
    add_disk(11'd2047, 11'd2047, 16'd0, 16'd0, 0);
    add_disk(11'd300, 11'd300, 16'd1600, 16'd0, 0);
    add_disk(11'd385, 11'd300, -16'sd1600, 16'd160, 0);
    tick(16'hffff, 0);
    tick(16'd0, 0);
    tick(16'd32768, 0);
    drain();

    // Zero-size disks: only an exact hit is blocked, coincident pairs skip exchange.
    write_reg(CFG_BALL_RADIUS, 11'd0);
    write_reg(CFG_ARENA_WIDTH, 11'd1);
    write_reg(CFG_ARENA_HEIGHT, 11'd2047);
    add_disk(11'd500, 11'd500, 16'd100, 16'd0, 0);
    add_disk(11'd500, 11'd500, 16'd0, 16'd0, 0);
    add_disk(11'd501, 11'd500, 16'd0, 16'd0, 0);
    tick(16'd0, 0);
    // fill the store so that further adds are refused
    for (int k = 0; k < 16; k++) add_disk(11'(k * 100 + 20), 11'd900, 16'd50, 16'd50, 0);
    tick(16'd4000, 0);
    random_phase(20);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    hold_off = 1;
    write_reg(CFG_BALL_RADIUS, 11'd255);
    write_reg(CFG_ARENA_WIDTH, 11'd2047);
    write_reg(CFG_ARENA_HEIGHT, 11'd1);
    random_phase(25);
    drain();

    write_reg(CFG_BALL_RADIUS, 11'd40);
    write_reg(CFG_ARENA_WIDTH, 11'd800);
    write_reg(CFG_ARENA_HEIGHT, 11'd600);
    stall_rand = 0;
    random_phase(20);
    stall_rand = 1;
    random_phase(25);
    drain();

    write_reg(CFG_BALL_RADIUS, 11'd12);
    write_reg(CFG_ARENA_WIDTH, 11'd640);
    write_reg(CFG_ARENA_HEIGHT, 11'd480);
    random_phase(35);
    drain();

    if (fail_count == 0)
      $display("tb_disk_collision_sim_step: clean");
    else
      $display("tb_disk_collision_sim_step: errors");
    $finish;
  end
endmodule
